// File: sv/qlbp_pkg.sv
// ============================================================================
// qlbp_pkg: shared types and constants of the backoff policy block
// Holds request codes, sequencer states, fixed-point constants, the warm
// table values and the bundles between the sequencer and the multiplier.
// ============================================================================
package qlbp_pkg;

    localparam int STATE_COUNT_DEFAULT = 10;
    localparam int ACTION_COUNT        = 3;

    // Operand widths of the shared bit-serial multiplier.
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 18;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam logic [15:0] LEARN_RATE_RESET = 16'd3277;
    localparam logic [15:0] DISCOUNT_RESET   = 16'd62259;
    localparam logic [31:0] RATE_RESET       = 32'd429496730;
    localparam logic [31:0] RATE_FLOOR       = 32'd42949673;
    localparam logic [31:0] SEED_WORD        = 32'd123456789;
    // 2^32 minus the Q0.32 decay factor 0.99995.
    localparam logic [MUL_B_W-1:0] DECAY_SUB = 18'd214748;

    localparam logic signed [31:0] ONE_Q16          = 32'sd65536;
    localparam logic signed [31:0] HALF_Q16         = 32'sd32768;
    localparam logic signed [31:0] TENTH_Q16        = 32'sd6554;
    localparam logic signed [31:0] FIFTH_Q16        = 32'sd13107;
    localparam logic signed [31:0] THREE_TENTHS_Q16 = 32'sd19661;

    // Configuration register indexes.
    localparam logic CFG_LEARN_RATE = 1'b0;
    localparam logic CFG_DISCOUNT   = 1'b1;

    typedef enum logic [1:0] {
        REQ_SELECT = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_DECAY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_READ,
        ST_SEL_MOD,
        ST_SEL_DONE,
        ST_UPD_READ,
        ST_UPD_GMUL,
        ST_UPD_AMUL,
        ST_DEC_MUL
    } seq_state_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] product;
    } mul_rsp_t;

    // Reset value of a table entry, by contention group.
    function automatic logic signed [31:0] warm_value(input logic [6:0] row,
                                                      input logic [1:0] col);
        logic signed [31:0] v;
        v = TENTH_Q16;
        if (row < 7'd3) begin
            case (col)
                2'd0:    v = ONE_Q16;
                2'd1:    v = HALF_Q16;
                default: v = TENTH_Q16;
            endcase
        end else if (row < 7'd7) begin
            case (col)
                2'd0:    v = FIFTH_Q16;
                2'd1:    v = ONE_Q16;
                default: v = THREE_TENTHS_Q16;
            endcase
        end else begin
            case (col)
                2'd0:    v = TENTH_Q16;
                2'd1:    v = THREE_TENTHS_Q16;
                default: v = ONE_Q16;
            endcase
        end
        return v;
    endfunction

    function automatic logic [31:0] xs_step(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

// File: sv/qlbp_serial_mul.sv
// ============================================================================
// qlbp_serial_mul: bit-serial signed by unsigned multiplier
// Takes one multiplier bit per cycle, most significant first, and pulses
// done with the full product after MUL_B_W steps.
// ============================================================================
module qlbp_serial_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  qlbp_pkg::mul_req_t req,
    output qlbp_pkg::mul_rsp_t rsp
);
    import qlbp_pkg::*;

    logic signed [MUL_P_W-1:0] acc_reg;
    logic signed [MUL_P_W-1:0] acc_next;
    logic signed [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0]        b_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [MUL_P_W-1:0]        addend;

    assign addend   = b_reg[MUL_B_W-1] ? {{MUL_B_W{a_reg[MUL_A_W-1]}}, a_reg}
                                       : '0;
    assign acc_next = {acc_reg[MUL_P_W-2:0], 1'b0} + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[MUL_B_W-2:0], 1'b0};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// File: sv/q_learning_backoff_policy_top.sv
// ============================================================================
// q_learning_backoff_policy_top: epsilon-greedy Q-table backoff policy
// Greedy selects scan their row, explored selects run the mod-3 loop, updates read and
// multiply twice, decays multiply once; the row scan reads one entry per cycle,
// the mod-3 loop takes 16 steps and each product 18 steps of the serial multiplier.
// One item is in work at a time, a dropped beat leaves the block idle, and a finished
// select also waits while an unaccepted result holds the output.
// Reset restores warm table values (via per-entry valid bits), epsilon, seed, alpha, gamma.
// ============================================================================
module q_learning_backoff_policy_top #(
    parameter int STATE_COUNT = qlbp_pkg::STATE_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beat.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cur_state[3:0], taken_action[5:4], reward[37:6],
    //        next_state[41:38], explore_draw[73:42], zero fill[79:74]
    input  logic [79:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result beat.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: chosen_action[1:0], zero fill[7:2]
    output logic [7:0]  m_axis_tdata,
    // tuser: explored[0]
    output logic        m_axis_tuser,
    // Configuration writes: index 0 learn_rate, index 1 discount.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import qlbp_pkg::*;

    localparam int ROW_W       = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int TABLE_DEPTH = STATE_COUNT * ACTION_COUNT;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Input field unpacking and row clamping.
    // ------------------------------------------------------------------
    req_t               in_req;
    logic [3:0]         in_cur_state;
    logic [1:0]         in_action;
    logic signed [31:0] in_reward;
    logic [3:0]         in_next_state;
    logic [31:0]        in_draw;
    logic               in_accept;

    assign in_req        = req_t'(s_axis_tuser);
    assign in_cur_state  = s_axis_tdata[3:0];
    assign in_action     = s_axis_tdata[5:4];
    assign in_reward     = s_axis_tdata[37:6];
    assign in_next_state = s_axis_tdata[41:38];
    assign in_draw       = s_axis_tdata[73:42];
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Rows beyond the table saturate to the last row.
    function automatic logic [ROW_W-1:0] clamp_row(input logic [3:0] s);
        logic [ROW_W-1:0] r;
        if ({3'b000, s} >= 7'(STATE_COUNT))
            r = ROW_W'(STATE_COUNT - 1);
        else
            r = ROW_W'(s);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                     input logic [1:0] col);
        return ADDR_W'({row, 1'b0}) + ADDR_W'(row) + ADDR_W'(col);
    endfunction

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    seq_state_t         state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        explore_rate_reg, explore_rate_next;
    logic [31:0]        xorshift_reg, xorshift_next;
    logic [15:0]        learn_rate_reg;
    logic [15:0]        discount_reg;
    logic [TABLE_DEPTH-1:0] valid_bits_reg;
    logic               rd_valid_reg;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [1:0]         col_reg, col_next;
    logic [ROW_W-1:0]   nrow_reg, nrow_next;
    logic signed [31:0] reward_reg, reward_next;
    logic signed [31:0] top_reg, top_next;
    logic [1:0]         best_reg, best_next;
    logic signed [31:0] q_reg, q_next;
    logic [31:0]        rnd_reg, rnd_next;
    logic [1:0]         mod_reg, mod_next;
    logic               sel_explore_reg, sel_explore_next;
    logic [1:0]         out_action_reg, out_action_next;
    logic               out_explored_reg, out_explored_next;
    logic [ROW_W-1:0]   rd_row_reg;
    logic [1:0]         rd_col_reg;
    logic signed [31:0] rd_data_reg;

    // Table memory with one write and one registered read port.
    logic signed [31:0] value_mem [TABLE_DEPTH];

    logic               rd_en;
    logic [ROW_W-1:0]   rd_row;
    logic [1:0]         rd_col;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;
    logic signed [31:0] rd_value;

    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;

    // Datapath intermediates.
    logic [2:0]         mod_sum;
    logic [1:0]         mod_new;
    logic signed [31:0] g_term;
    logic signed [33:0] diff;
    logic signed [36:0] q_sum;
    logic [20:0]        rate_ceil;
    logic [31:0]        rate_dec;

    assign rd_addr = entry_addr(rd_row, rd_col);
    assign wr_addr = entry_addr(row_reg, col_reg);

    // A never-written entry still holds its warm reset value.
    assign rd_value = rd_valid_reg ? rd_data_reg
                                   : warm_value(7'(rd_row_reg), rd_col_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b000000, out_action_reg};
    assign m_axis_tuser  = out_explored_reg;

    qlbp_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Mod-3 of the random word, two bits per step: 4 is 1 modulo 3, so each
    // digit just adds to the running remainder.
    assign mod_sum = {1'b0, mod_reg} + {1'b0, rnd_reg[31:30]};
    assign mod_new = (mod_sum >= 3'd3) ? 2'(mod_sum - 3'd3) : mod_sum[1:0];

    // Update arithmetic. Dropping the low product bits is a floor shift.
    assign g_term = mul_rsp.product[47:16];
    assign diff   = {{2{reward_reg[31]}}, reward_reg} + {{2{g_term[31]}}, g_term}
                  - {{2{q_reg[31]}}, q_reg};
    assign q_sum  = {{5{q_reg[31]}}, q_reg}
                  + {mul_rsp.product[MUL_P_W-1], mul_rsp.product[MUL_P_W-1:16]};

    // Decay: rate * (2^32 - DECAY_SUB) / 2^32, floored, is rate minus the
    // rounded-up high word of rate * DECAY_SUB.
    assign rate_ceil = {1'b0, mul_rsp.product[51:32]} + {20'd0, |mul_rsp.product[31:0]};
    assign rate_dec  = explore_rate_reg - 32'(rate_ceil);

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath controls.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        explore_rate_next = explore_rate_reg;
        xorshift_next     = xorshift_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        nrow_next         = nrow_reg;
        reward_next       = reward_reg;
        top_next          = top_reg;
        best_next         = best_reg;
        q_next            = q_reg;
        rnd_next          = rnd_reg;
        mod_next          = mod_reg;
        sel_explore_next  = sel_explore_reg;
        out_action_next   = out_action_reg;
        out_explored_next = out_explored_reg;
        rd_en             = 1'b0;
        rd_row            = row_reg;
        rd_col            = step_reg[1:0];
        wr_en             = 1'b0;
        wr_data           = q_sum[31:0];
        mul_req.start     = 1'b0;
        mul_req.a         = {{2{top_reg[31]}}, top_reg};
        mul_req.b         = {2'b00, discount_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_req)
                        REQ_SELECT:
                        begin
                            row_next = clamp_row(in_cur_state);
                            if (in_draw < explore_rate_reg)
                            begin
                                xorshift_next    = xs_step(xorshift_reg);
                                rnd_next         = xs_step(xorshift_reg);
                                mod_next         = 2'd0;
                                step_next        = 5'd15;
                                sel_explore_next = 1'b1;
                                state_next       = ST_SEL_MOD;
                            end
                            else
                            begin
                                step_next        = 5'd0;
                                sel_explore_next = 1'b0;
                                state_next       = ST_SEL_READ;
                            end
                        end
                        REQ_UPDATE:
                        begin
                            // Column three names no action: the beat is dropped.
                            if (in_action < 2'(ACTION_COUNT))
                            begin
                                row_next    = clamp_row(in_cur_state);
                                col_next    = in_action;
                                nrow_next   = clamp_row(in_next_state);
                                reward_next = in_reward;
                                step_next   = 5'd0;
                                state_next  = ST_UPD_READ;
                            end
                        end
                        REQ_DECAY:
                        begin
                            mul_req.start = 1'b1;
                            mul_req.a     = {2'b00, explore_rate_reg};
                            mul_req.b     = DECAY_SUB;
                            state_next    = ST_DEC_MUL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEL_READ, ST_UPD_READ:
            begin
                // Issue one column read per step; data arrives a step later.
                if (step_reg < 5'd3)
                begin
                    rd_en  = 1'b1;
                    rd_row = (state_reg == ST_SEL_READ) ? row_reg : nrow_reg;
                end
                else if (step_reg == 5'd3 && state_reg == ST_UPD_READ)
                begin
                    rd_en  = 1'b1;
                    rd_row = row_reg;
                    rd_col = col_reg;
                end
                // Running first maximum over the row.
                if (step_reg >= 5'd1 && step_reg <= 5'd3)
                begin
                    if (step_reg == 5'd1 || rd_value > top_reg)
                    begin
                        top_next  = rd_value;
                        best_next = step_reg[1:0] - 2'd1;
                    end
                end
                step_next = step_reg + 5'd1;
                if (state_reg == ST_SEL_READ && step_reg == 5'd3)
                    state_next = ST_SEL_DONE;
                if (state_reg == ST_UPD_READ && step_reg == 5'd4)
                begin
                    q_next        = rd_value;
                    mul_req.start = 1'b1;
                    state_next    = ST_UPD_GMUL;
                end
            end

            ST_SEL_MOD:
            begin
                mod_next  = mod_new;
                rnd_next  = {rnd_reg[29:0], 2'b00};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    best_next  = mod_new;
                    state_next = ST_SEL_DONE;
                end
            end

            ST_SEL_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next    = 1'b1;
                    out_action_next   = best_reg;
                    out_explored_next = sel_explore_reg;
                    state_next        = ST_IDLE;
                end
            end

            ST_UPD_GMUL:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = diff;
                    mul_req.b     = {2'b00, learn_rate_reg};
                    state_next    = ST_UPD_AMUL;
                end
            end

            ST_UPD_AMUL:
            begin
                if (mul_rsp.done)
                begin
                    wr_en = 1'b1;
                    if (q_sum[36:31] != {6{q_sum[36]}})
                        wr_data = q_sum[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    state_next = ST_IDLE;
                end
            end

            ST_DEC_MUL:
            begin
                if (mul_rsp.done)
                begin
                    explore_rate_next = (rate_dec < RATE_FLOOR) ? RATE_FLOOR : rate_dec;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            explore_rate_reg <= RATE_RESET;
            xorshift_reg     <= SEED_WORD;
            learn_rate_reg   <= LEARN_RATE_RESET;
            discount_reg     <= DISCOUNT_RESET;
            valid_bits_reg   <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            explore_rate_reg <= explore_rate_next;
            xorshift_reg     <= xorshift_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEARN_RATE)
                    learn_rate_reg <= cfg_data;
                if (cfg_index == CFG_DISCOUNT)
                    discount_reg <= cfg_data;
            end
            if (wr_en)
                valid_bits_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_bits_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        row_reg          <= row_next;
        col_reg          <= col_next;
        nrow_reg         <= nrow_next;
        reward_reg       <= reward_next;
        top_reg          <= top_next;
        best_reg         <= best_next;
        q_reg            <= q_next;
        rnd_reg          <= rnd_next;
        mod_reg          <= mod_next;
        sel_explore_reg  <= sel_explore_next;
        out_action_reg   <= out_action_next;
        out_explored_reg <= out_explored_next;
        if (rd_en)
        begin
            rd_row_reg <= rd_row;
            rd_col_reg <= rd_col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            value_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= value_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The exploration rate never drops below its floor.
    assert property (@(posedge clk) disable iff (!rst_n)
        explore_rate_reg >= RATE_FLOOR)
    else $error("exploration rate below floor");

    // A multiplier result only ever arrives while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_UPD_GMUL || state_reg == ST_UPD_AMUL
                          || state_reg == ST_DEC_MUL))
    else $error("multiplier result with no consumer");

    // A finished select holds while an unaccepted result occupies the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL_DONE && out_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_SEL_DONE))
    else $error("select result would overwrite a pending beat");

endmodule

// File: sim/tb_q_learning_backoff_policy_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_q_learning_backoff_policy_top: self-checking bench of the backoff policy
// A queue of request beats feeds a clocked driver. The driver keeps its own
// copy of the Q table, the exploration rate and the xorshift generator, and
// works out the action each select beat must return. A clocked monitor
// checks every result beat against the oldest expected action.
// ============================================================================
module tb_q_learning_backoff_policy_top;

    import qlbp_pkg::*;

    localparam int STATE_COUNT = STATE_COUNT_DEFAULT;
    localparam int TABLE_DEPTH = STATE_COUNT * ACTION_COUNT;

    // 0.99995 in Q0.32, the factor of one decay step.
    localparam logic [31:0] DECAY_FACTOR = 32'd4294752548;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    // The slowest item is an update; ENGINE_SETTLE quiet cycles are enough for
    // the engine to finish whatever it still holds.
    localparam int ENGINE_SETTLE    = 80;
    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_PER_PHASE = 390;
    // Decay steps run just before the threshold probes at the end.
    localparam int DECAY_BURST      = 16;

    // Idle profiles of the four random phases, in percent of cycles.
    localparam int SEND_IDLE  [4] = '{0, 80, 0, 32};
    localparam int RECV_STALL [4] = '{0, 0, 80, 32};

    // One request beat, unpacked into its fields.
    typedef struct {
        req_t        kind;
        logic [3:0]  cur_state;
        logic [1:0]  taken_action;
        logic [31:0] reward;
        logic [3:0]  next_state;
        logic [31:0] draw;
    } request_t;

    // What a select beat must answer.
    typedef struct {
        logic [1:0] action;
        logic       explored;
    } action_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = REQ_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_LEARN_RATE;
    logic [15:0] cfg_data = '0;

    // Mirror of the block's state, advanced on every accepted request beat.
    logic signed [31:0] q_table [TABLE_DEPTH];
    logic [31:0]        eps_rate;
    logic [31:0]        xs_word;
    logic [15:0]        alpha_q;
    logic [15:0]        gamma_q;

    request_t     queued_requests [$];
    action_beat_t awaited_actions [$];
    request_t     offered;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_arm       = 1'b0;
    bit hold_used      = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int mismatches    = 0;
    int beats_in      = 0;
    int results_seen  = 0;
    int select_count  = 0;
    int explore_count = 0;
    int learn_count   = 0;
    int decay_count   = 0;
    int ignored_count = 0;

    q_learning_backoff_policy_top #(
        .STATE_COUNT(STATE_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Rows past the end of the table fold onto the last row.
    function automatic int unsigned clamp_row(input logic [3:0] row);
        return (row >= STATE_COUNT) ? STATE_COUNT - 1 : row;
    endfunction

    // Lowest column holding the row maximum; a tie goes to the lower column.
    function automatic int unsigned best_column(input int unsigned row);
        int unsigned best;
        logic signed [31:0] top;
        best = 0;
        top  = q_table[row * ACTION_COUNT];
        for (int c = 1; c < ACTION_COUNT; c++)
        begin
            if (q_table[row * ACTION_COUNT + c] > top)
            begin
                top  = q_table[row * ACTION_COUNT + c];
                best = c;
            end
        end
        return best;
    endfunction

    // Advances the mirrored state by one accepted request beat and queues the
    // action that a select must produce.
    function automatic void policy_step(input request_t r);
        int unsigned        row;
        int unsigned        nrow;
        logic signed [63:0] best_next;
        logic signed [63:0] cur_q;
        logic signed [63:0] gamma_wide;
        logic signed [63:0] alpha_wide;
        logic signed [63:0] reward_wide;
        logic signed [63:0] disc_term;
        logic signed [63:0] delta;
        logic signed [63:0] new_q;
        logic [63:0]        scaled;
        logic [31:0]        x;
        action_beat_t       beat;
        row  = clamp_row(r.cur_state);
        nrow = clamp_row(r.next_state);
        case (r.kind)
            REQ_SELECT:
            begin
                select_count++;
                if (r.draw < eps_rate)
                begin
                    x = xs_word;
                    x = x ^ (x << 13);
                    x = x ^ (x >> 17);
                    x = x ^ (x << 5);
                    xs_word = x;
                    beat.action   = 2'(x % ACTION_COUNT);
                    beat.explored = 1'b1;
                    explore_count++;
                end
                else
                begin
                    beat.action   = 2'(best_column(row));
                    beat.explored = 1'b0;
                end
                awaited_actions = {awaited_actions, beat};
            end
            REQ_UPDATE:
            begin
                if (r.taken_action >= ACTION_COUNT)
                begin
                    ignored_count++;
                end
                else
                begin
                    learn_count++;
                    best_next   = q_table[nrow * ACTION_COUNT + best_column(nrow)];
                    cur_q       = q_table[row * ACTION_COUNT + r.taken_action];
                    gamma_wide  = {48'd0, gamma_q};
                    alpha_wide  = {48'd0, alpha_q};
                    reward_wide = $signed(r.reward);
                    // Arithmetic right shifts give the floor of each division.
                    disc_term = (gamma_wide * best_next) >>> 16;
                    delta     = reward_wide + disc_term - cur_q;
                    new_q     = cur_q + ((alpha_wide * delta) >>> 16);
                    if (new_q > Q_MAX)
                        new_q = Q_MAX;
                    if (new_q < Q_MIN)
                        new_q = Q_MIN;
                    q_table[row * ACTION_COUNT + r.taken_action] = new_q[31:0];
                end
            end
            REQ_DECAY:
            begin
                decay_count++;
                scaled   = {32'd0, eps_rate} * {32'd0, DECAY_FACTOR};
                x        = scaled[63:32];
                eps_rate = (x < RATE_FLOOR) ? RATE_FLOOR : x;
            end
            default:
            begin
                ignored_count++;
            end
        endcase
    endfunction

    task automatic push_request(input req_t kind, input logic [3:0] cur,
                                input logic [1:0] act, input logic [31:0] rew,
                                input logic [3:0] nxt, input logic [31:0] draw);
        request_t r;
        r.kind         = kind;
        r.cur_state    = cur;
        r.taken_action = act;
        r.reward       = rew;
        r.next_state   = nxt;
        r.draw         = draw;
        queued_requests = {queued_requests, r};
    endtask

    // Random request: mostly rows in range, rewards near the table's scale,
    // draws around the exploration rate, and a little noise the block ignores.
    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            r.kind = REQ_SELECT;
        else if (pick < 80)
            r.kind = REQ_UPDATE;
        else if (pick < 93)
            r.kind = REQ_DECAY;
        else
            r.kind = REQ_NONE;
        r.cur_state  = ($urandom_range(99) < 85) ? 4'($urandom_range(9))
                                                 : 4'($urandom_range(15, 10));
        r.next_state = ($urandom_range(99) < 85) ? 4'($urandom_range(9))
                                                 : 4'($urandom_range(15, 10));
        r.taken_action = ($urandom_range(99) < 92) ? 2'($urandom_range(2)) : 2'd3;
        case ($urandom_range(3))
            0:       r.reward = 32'($urandom_range(262143)) - 32'd131072;
            1:       r.reward = 32'($urandom_range(2097151)) - 32'd1048576;
            2:       r.reward = $urandom;
            default:
            begin
                case ($urandom_range(3))
                    0:       r.reward = 32'h7FFF_FFFF;
                    1:       r.reward = 32'h8000_0000;
                    2:       r.reward = 32'h0000_0000;
                    default: r.reward = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        case ($urandom_range(2))
            0:       r.draw = $urandom;
            1:       r.draw = $urandom_range(2 * RATE_RESET);
            default: r.draw = eps_rate + 32'($urandom_range(64)) - 32'd32;
        endcase
        return r;
    endfunction

    // Waits until every queued beat is sent and answered, then lets the
    // engine finish an update or decay that has no result to show for it.
    task automatic settle_engine();
        while (queued_requests.size() != 0 || s_axis_tvalid || awaited_actions.size() != 0)
            @(posedge clk);
        repeat (ENGINE_SETTLE) @(posedge clk);
    endtask

    // Writes alpha then gamma back to back; valid stays high between the two
    // beats. Called only at a rising edge while the engine is idle.
    task automatic program_rates(input logic [15:0] alpha, input logic [15:0] gamma);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LEARN_RATE;
        cfg_data  <= alpha;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        alpha_q = alpha;
        cfg_index <= CFG_DISCOUNT;
        cfg_data  <= gamma;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        gamma_q = gamma;
        cfg_valid <= 1'b0;
    endtask

    // Driver: predicts each accepted request beat, then offers the next one
    // unless the current idle profile says to leave a gap. A beat on offer
    // stays put until it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                policy_step(offered);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = queued_requests.pop_front();
                    s_axis_tdata  <= {6'd0, offered.draw, offered.next_state, offered.reward,
                                      offered.taken_action, offered.cur_state};
                    s_axis_tuser  <= offered.kind;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed once. While it runs the sender keeps
    // offering beats, so the engine fills up and has to stall its input.
    always @(posedge clk)
    begin
        if (hold_arm && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every accepted result beat is checked against the oldest
    // expected action; the fill bits of tdata must stay zero.
    always @(posedge clk)
    begin
        action_beat_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (awaited_actions.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: tdata %0h explored %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = awaited_actions.pop_front();
                    if (m_axis_tdata !== {6'd0, want.action} || m_axis_tuser !== want.explored)
                    begin
                        $display("%0t: action mismatch: expected %0d explored %0b, got %0h explored %0b",
                                 $time, want.action, want.explored, m_axis_tdata, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too many cycles without a beat on any channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("q_learning_backoff_policy_top test failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        // Warm table: low rows favor spinning, middle rows yielding, the
        // most contended rows sleeping.
        for (int s = 0; s < STATE_COUNT; s++)
        begin
            if (s < 3)
            begin
                q_table[s * ACTION_COUNT]     = ONE_Q16;
                q_table[s * ACTION_COUNT + 1] = HALF_Q16;
                q_table[s * ACTION_COUNT + 2] = TENTH_Q16;
            end
            else if (s < 7)
            begin
                q_table[s * ACTION_COUNT]     = FIFTH_Q16;
                q_table[s * ACTION_COUNT + 1] = ONE_Q16;
                q_table[s * ACTION_COUNT + 2] = THREE_TENTHS_Q16;
            end
            else
            begin
                q_table[s * ACTION_COUNT]     = TENTH_Q16;
                q_table[s * ACTION_COUNT + 1] = THREE_TENTHS_Q16;
                q_table[s * ACTION_COUNT + 2] = ONE_Q16;
            end
        end
        eps_rate = RATE_RESET;
        xs_word  = SEED_WORD;
        alpha_q  = LEARN_RATE_RESET;
        gamma_q  = DISCOUNT_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset rates: explored and greedy selects,
        // draws on both sides of the rate, rows past the end of the table, an
        // update of the missing fourth column, the unused request type,
        // extreme rewards and a couple of decays.
        push_request(REQ_SELECT, 4'd0, 2'd0, 32'd0, 4'd0, 32'd0);
        push_request(REQ_SELECT, 4'd0, 2'd3, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd5, 2'd1, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd9, 2'd2, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd15, 2'd0, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd10, 2'd0, 32'd0, 4'd0, 32'h8000_0000);
        push_request(REQ_SELECT, 4'd0, 2'd0, 32'd0, 4'd0, RATE_RESET - 32'd1);
        push_request(REQ_SELECT, 4'd3, 2'd0, 32'd0, 4'd0, RATE_RESET);
        push_request(REQ_UPDATE, 4'd0, 2'd3, 32'h7FFF_FFFF, 4'd0, 32'd0);
        push_request(REQ_NONE, 4'd15, 2'd3, 32'hFFFF_FFFF, 4'd15, 32'd0);
        push_request(REQ_SELECT, 4'd0, 2'd0, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_UPDATE, 4'd1, 2'd2, 32'h7FFF_FFFF, 4'd15, 32'hFFFF_FFFF);
        push_request(REQ_UPDATE, 4'd2, 2'd0, 32'h8000_0000, 4'd0, 32'd0);
        push_request(REQ_UPDATE, 4'd14, 2'd1, 32'd0, 4'd12, 32'd0);
        push_request(REQ_DECAY, 4'd0, 2'd0, 32'd0, 4'd0, 32'd0);
        push_request(REQ_DECAY, 4'd15, 2'd3, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd1, 2'd0, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd2, 2'd0, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd9, 2'd0, 32'd0, 4'd0, 32'hFFFF_FFFF);
        settle_engine();

        // With both rates at their maximum, a huge reward saturates an entry.
        // Doing it to two columns of one row leaves a tie at the top, which
        // the lower column has to win.
        program_rates(16'hFFFF, 16'hFFFF);
        push_request(REQ_UPDATE, 4'd3, 2'd0, 32'h7FFF_FFFF, 4'd3, 32'd0);
        push_request(REQ_UPDATE, 4'd3, 2'd1, 32'h7FFF_FFFF, 4'd3, 32'd0);
        push_request(REQ_SELECT, 4'd3, 2'd0, 32'd0, 4'd0, 32'hFFFF_FFFF);
        push_request(REQ_SELECT, 4'd3, 2'd0, 32'd0, 4'd0, 32'd1);

        // Random phases, one per idle profile, each under its own rates.
        for (int p = 0; p < 4; p++)
        begin
            if (p == 1)
                program_rates(16'd0, 16'd0);
            else if (p == 2)
                program_rates(16'($urandom), 16'($urandom));
            else if (p == 3)
                program_rates(LEARN_RATE_RESET, DISCOUNT_RESET);
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            if (p == 0)
                hold_arm = 1'b1;
            repeat (RANDOM_PER_PHASE) queued_requests = {queued_requests, random_request()};
            settle_engine();
        end

        // A short run of decays, then draws right at the decayed rate: one
        // below it explores, the rate itself and one above take the greedy
        // path. The threshold is probed again after one more decay.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DECAY_BURST) push_request(REQ_DECAY, 4'd0, 2'd0, 32'd0, 4'd0, 32'd0);
        settle_engine();
        push_request(REQ_SELECT, 4'd4, 2'd0, 32'd0, 4'd0, eps_rate - 32'd1);
        push_request(REQ_SELECT, 4'd8, 2'd0, 32'd0, 4'd0, eps_rate);
        push_request(REQ_SELECT, 4'd0, 2'd0, 32'd0, 4'd0, eps_rate + 32'd1);
        push_request(REQ_DECAY, 4'd0, 2'd0, 32'd0, 4'd0, 32'd0);
        settle_engine();
        push_request(REQ_SELECT, 4'd6, 2'd0, 32'd0, 4'd0, eps_rate - 32'd1);
        push_request(REQ_SELECT, 4'd6, 2'd0, 32'd0, 4'd0, eps_rate);
        settle_engine();

        $display("Run covered %0d request beats: %0d selects (%0d explored), %0d updates, %0d decays, %0d ignored.",
                 beats_in, select_count, explore_count, learn_count, decay_count,
                 ignored_count);
        $display("Checked %0d action beats over four idle profiles; final exploration rate %0d.",
                 results_seen, eps_rate);
        if (mismatches == 0)
            $display("q_learning_backoff_policy_top test passed");
        else
            $display("q_learning_backoff_policy_top test failed");
        $finish;
    end

endmodule
